// ===== src/clifford_gate_pauli_update_core_macros.svh =====
// ---------------------------------------------------------------------------
// clifford gate pauli update core assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef CLIFFORD_GATE_PAULI_UPDATE_CORE_MACROS_SVH
`define CLIFFORD_GATE_PAULI_UPDATE_CORE_MACROS_SVH

// same-cycle implication
`define CGPU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cgpu assertion failed");

// next-cycle implication
`define CGPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cgpu assertion failed");

`endif

// ===== src/cgpu_pkg.sv =====
// ---------------------------------------------------------------------------
// cgpu_pkg
// shared types, codes and phase tables of the pauli string update core
// ---------------------------------------------------------------------------
package cgpu_pkg;

  localparam int unsigned STR_W         = 64;
  localparam int unsigned QIDX_W        = 6;
  localparam int unsigned CNT_W         = 7;
  localparam int unsigned MAX_QUBITS_DEF = 64;

  typedef enum logic [4:0] {
    OP_LOAD    = 5'd0,
    OP_H       = 5'd1,
    OP_S       = 5'd2,
    OP_SD      = 5'd3,
    OP_X       = 5'd4,
    OP_Y       = 5'd5,
    OP_Z       = 5'd6,
    OP_SQRTX   = 5'd7,
    OP_SQRTY   = 5'd8,
    OP_SQRTZ   = 5'd9,
    OP_SQRTXD  = 5'd10,
    OP_SQRTYD  = 5'd11,
    OP_SQRTZD  = 5'd12,
    OP_CX      = 5'd13,
    OP_CY      = 5'd14,
    OP_CZ      = 5'd15,
    OP_SWAP    = 5'd16
  } opcode_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_SAME  = 2'd2
  } err_e;

  // phase added by H or S, indexed by {z, x}
  localparam logic [1:0] SINGLE_PHASE_TAB [0:3] = '{2'd0, 2'd0, 2'd0, 2'd2};
  // phase added by CX, indexed by {za, xa, zb, xb}
  localparam logic [1:0] CX_PHASE_TAB [0:15] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2
  };

  // whole pauli string
  typedef struct packed {
    logic [STR_W-1:0] x;
    logic [STR_W-1:0] z;
    logic [1:0]       ph;
  } pstr_t;

  // the two qubits a gate touches plus the running phase
  typedef struct packed {
    logic       xa;
    logic       za;
    logic       xb;
    logic       zb;
    logic [1:0] ph;
  } loc_t;

  function automatic loc_t loc_swap(loc_t l);
    loc_t r;
    r    = l;
    r.xa = l.xb;
    r.za = l.zb;
    r.xb = l.xa;
    r.zb = l.za;
    return r;
  endfunction

  function automatic loc_t loc_h_a(loc_t l);
    loc_t r;
    r    = l;
    r.ph = l.ph + SINGLE_PHASE_TAB[{l.za, l.xa}];
    r.xa = l.za;
    r.za = l.xa;
    return r;
  endfunction

  function automatic loc_t loc_s_a(loc_t l);
    loc_t r;
    r    = l;
    r.ph = l.ph + SINGLE_PHASE_TAB[{l.za, l.xa}];
    r.za = l.xa ^ l.za;
    return r;
  endfunction

  function automatic loc_t loc_sd_a(loc_t l);
    return loc_s_a(loc_s_a(loc_s_a(l)));
  endfunction

  function automatic loc_t loc_z_a(loc_t l);
    return loc_s_a(loc_s_a(l));
  endfunction

  function automatic loc_t loc_h_b(loc_t l);
    return loc_swap(loc_h_a(loc_swap(l)));
  endfunction

  // control a, target b
  function automatic loc_t loc_cx_ab(loc_t l);
    loc_t r;
    r    = l;
    r.ph = l.ph + CX_PHASE_TAB[{l.za, l.xa, l.zb, l.xb}];
    r.xb = l.xa ^ l.xb;
    r.za = l.za ^ l.zb;
    return r;
  endfunction

  function automatic loc_t loc_cx_ba(loc_t l);
    return loc_swap(loc_cx_ab(loc_swap(l)));
  endfunction

endpackage

// ===== src/clifford_gate_pauli_update_core.sv =====
// result: an accepted gate or load passes the input register, then the result
//   register (the string register), before out_valid_o rises
// throughput: one gate or load per cycle unless the output stalls; the string register
//   feeds straight back into the gate logic, so consecutive gates chain without bubbles
// reset: string clears to identity with phase 0, qubit_count to 64, both stages empty
// ---------------------------------------------------------------------------
// clifford_gate_pauli_update_core
// conjugates a held pauli string by one clifford gate, or replaces it by a load, per transfer
// ---------------------------------------------------------------------------
module clifford_gate_pauli_update_core #(
  parameter int unsigned MAX_QUBITS = cgpu_pkg::MAX_QUBITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cgpu_pkg::CNT_W-1:0]  cfg_qubit_count_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [4:0]                  opcode_i,
  input  logic [cgpu_pkg::QIDX_W-1:0] qubit_a_i,
  input  logic [cgpu_pkg::QIDX_W-1:0] qubit_b_i,
  input  logic [cgpu_pkg::STR_W-1:0]  new_x_bits_i,
  input  logic [cgpu_pkg::STR_W-1:0]  new_z_bits_i,
  input  logic [1:0]                  new_phase_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cgpu_pkg::STR_W-1:0]  x_out_o,
  output logic [cgpu_pkg::STR_W-1:0]  z_out_o,
  output logic [1:0]                  phase_out_o,
  output logic [1:0]                  error_code_o
);

  logic                        cnt_we;
  logic [cgpu_pkg::CNT_W-1:0]  cnt_q;

  logic                        in_vld_q;
  logic [4:0]                  op_q;
  logic [cgpu_pkg::QIDX_W-1:0] qa_q;
  logic [cgpu_pkg::QIDX_W-1:0] qb_q;
  cgpu_pkg::pstr_t             load_q;

  cgpu_pkg::pstr_t             str_q;
  cgpu_pkg::pstr_t             str_d;
  logic [1:0]                  err_d;
  logic [1:0]                  err_q;
  logic                        out_vld_q;

  logic                        out_free;
  logic                        advance;
  logic                        in_xfer;

  assign cfg_ready_o = 1'b1;
  assign cnt_we      = cfg_valid_i & cfg_ready_o;

  assign out_free   = ~out_vld_q | out_ready_i;
  assign advance    = in_vld_q & out_free;
  assign in_ready_o = ~in_vld_q | out_free;
  assign in_xfer    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= cgpu_pkg::CNT_W'(cgpu_pkg::STR_W);
    end else if (cnt_we) begin
      cnt_q <= cfg_qubit_count_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= opcode_i;
      qa_q      <= qubit_a_i;
      qb_q      <= qubit_b_i;
      load_q.x  <= new_x_bits_i;
      load_q.z  <= new_z_bits_i;
      load_q.ph <= new_phase_i;
    end
  end

  cgpu_gate_unit #(
    .MAX_QUBITS (MAX_QUBITS)
  ) u_gate (
    .opcode_i      (op_q),
    .qubit_a_i     (qa_q),
    .qubit_b_i     (qb_q),
    .load_i        (load_q),
    .cur_i         (str_q),
    .qubit_count_i (cnt_q),
    .nxt_o         (str_d),
    .err_o         (err_d)
  );

  // string state doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        str_q <= str_d;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      err_q <= err_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign x_out_o      = str_q.x;
  assign z_out_o      = str_q.z;
  assign phase_out_o  = str_q.ph;
  assign error_code_o = err_q;

endmodule

// ===== src/cgpu_gate_unit.sv =====
// ---------------------------------------------------------------------------
// cgpu_gate_unit
// applies one gate or load to the current pauli string, with index checks
// ---------------------------------------------------------------------------
module cgpu_gate_unit #(
  parameter int unsigned MAX_QUBITS = cgpu_pkg::MAX_QUBITS_DEF
) (
  input  logic [4:0]                   opcode_i,
  input  logic [cgpu_pkg::QIDX_W-1:0]  qubit_a_i,
  input  logic [cgpu_pkg::QIDX_W-1:0]  qubit_b_i,
  input  cgpu_pkg::pstr_t              load_i,
  input  cgpu_pkg::pstr_t              cur_i,
  input  logic [cgpu_pkg::CNT_W-1:0]   qubit_count_i,
  output cgpu_pkg::pstr_t              nxt_o,
  output logic [1:0]                   err_o
);

  localparam logic [cgpu_pkg::CNT_W-1:0] MaxCnt = cgpu_pkg::CNT_W'(MAX_QUBITS);

  logic [cgpu_pkg::CNT_W-1:0] cnt;
  logic [cgpu_pkg::STR_W-1:0] mask;
  logic                       a_bad;
  logic                       b_bad;
  cgpu_pkg::loc_t             lin;
  cgpu_pkg::loc_t             lout;
  logic                       apply_one;
  logic                       apply_two;

  assign cnt   = (qubit_count_i < MaxCnt) ? qubit_count_i : MaxCnt;
  assign a_bad = {1'b0, qubit_a_i} >= cnt;
  assign b_bad = {1'b0, qubit_b_i} >= cnt;

  always_comb begin
    for (int i = 0; i < int'(cgpu_pkg::STR_W); i++) begin
      mask[i] = cgpu_pkg::CNT_W'(i) < cnt;
    end
  end

  assign lin.xa = cur_i.x[qubit_a_i];
  assign lin.za = cur_i.z[qubit_a_i];
  assign lin.xb = cur_i.x[qubit_b_i];
  assign lin.zb = cur_i.z[qubit_b_i];
  assign lin.ph = cur_i.ph;

  always_comb begin
    lout      = lin;
    apply_one = 1'b0;
    apply_two = 1'b0;
    err_o     = cgpu_pkg::ERR_OK;
    case (opcode_i)
      cgpu_pkg::OP_H, cgpu_pkg::OP_S, cgpu_pkg::OP_SD, cgpu_pkg::OP_X,
      cgpu_pkg::OP_Y, cgpu_pkg::OP_Z, cgpu_pkg::OP_SQRTX, cgpu_pkg::OP_SQRTY,
      cgpu_pkg::OP_SQRTZ, cgpu_pkg::OP_SQRTXD, cgpu_pkg::OP_SQRTYD,
      cgpu_pkg::OP_SQRTZD: begin
        if (a_bad) begin
          err_o = cgpu_pkg::ERR_RANGE;
        end else begin
          apply_one = 1'b1;
        end
      end
      cgpu_pkg::OP_CX, cgpu_pkg::OP_CY, cgpu_pkg::OP_CZ, cgpu_pkg::OP_SWAP: begin
        if (a_bad || b_bad) begin
          err_o = cgpu_pkg::ERR_RANGE;
        end else if (qubit_a_i == qubit_b_i) begin
          err_o = cgpu_pkg::ERR_SAME;
        end else begin
          apply_two = 1'b1;
        end
      end
      default: ;
    endcase

    case (opcode_i)
      cgpu_pkg::OP_H:      lout = cgpu_pkg::loc_h_a(lin);
      cgpu_pkg::OP_S:      lout = cgpu_pkg::loc_s_a(lin);
      cgpu_pkg::OP_SD:     lout = cgpu_pkg::loc_sd_a(lin);
      cgpu_pkg::OP_X:      lout = cgpu_pkg::loc_h_a(cgpu_pkg::loc_z_a(cgpu_pkg::loc_h_a(lin)));
      cgpu_pkg::OP_Y:      lout = cgpu_pkg::loc_z_a(cgpu_pkg::loc_h_a(
                                    cgpu_pkg::loc_z_a(cgpu_pkg::loc_h_a(lin))));
      cgpu_pkg::OP_Z:      lout = cgpu_pkg::loc_z_a(lin);
      cgpu_pkg::OP_SQRTX:  lout = cgpu_pkg::loc_sd_a(cgpu_pkg::loc_h_a(
                                    cgpu_pkg::loc_sd_a(lin)));
      cgpu_pkg::OP_SQRTY:  lout = cgpu_pkg::loc_h_a(cgpu_pkg::loc_z_a(lin));
      cgpu_pkg::OP_SQRTZ:  lout = cgpu_pkg::loc_s_a(lin);
      cgpu_pkg::OP_SQRTXD: lout = cgpu_pkg::loc_s_a(cgpu_pkg::loc_h_a(cgpu_pkg::loc_s_a(lin)));
      cgpu_pkg::OP_SQRTYD: lout = cgpu_pkg::loc_z_a(cgpu_pkg::loc_h_a(lin));
      cgpu_pkg::OP_SQRTZD: lout = cgpu_pkg::loc_sd_a(lin);
      cgpu_pkg::OP_CX:     lout = cgpu_pkg::loc_cx_ab(lin);
      // cz(a,b) = h(b) cx(a,b) h(b)
      cgpu_pkg::OP_CZ:     lout = cgpu_pkg::loc_h_b(cgpu_pkg::loc_cx_ab(
                                    cgpu_pkg::loc_h_b(lin)));
      // cy(a,b) = s(a) h(a) [h(a) cx(b,a) h(a)] h(a) sd(a), single gates all on qubit a
      cgpu_pkg::OP_CY:     lout = cgpu_pkg::loc_sd_a(cgpu_pkg::loc_h_a(
                                    cgpu_pkg::loc_h_a(cgpu_pkg::loc_cx_ba(cgpu_pkg::loc_h_a(
                                    cgpu_pkg::loc_h_a(cgpu_pkg::loc_s_a(lin)))))));
      cgpu_pkg::OP_SWAP:   lout = cgpu_pkg::loc_cx_ab(cgpu_pkg::loc_cx_ba(
                                    cgpu_pkg::loc_cx_ab(lin)));
      default:             lout = lin;
    endcase
  end

  always_comb begin
    nxt_o = cur_i;
    if (opcode_i == cgpu_pkg::OP_LOAD) begin
      nxt_o.x  = load_i.x & mask;
      nxt_o.z  = load_i.z & mask;
      nxt_o.ph = load_i.ph;
    end else if (apply_one || apply_two) begin
      nxt_o.ph           = lout.ph;
      nxt_o.x[qubit_a_i] = lout.xa;
      nxt_o.z[qubit_a_i] = lout.za;
      if (apply_two) begin
        nxt_o.x[qubit_b_i] = lout.xb;
        nxt_o.z[qubit_b_i] = lout.zb;
      end
    end
  end

endmodule

// ===== src/cgpu_checker.sv =====
// ---------------------------------------------------------------------------
// cgpu_checker
// port-level checks of the pauli string update core, bound to the top level
// ---------------------------------------------------------------------------
`include "clifford_gate_pauli_update_core_macros.svh"

module cgpu_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [cgpu_pkg::STR_W-1:0] x_out_o,
  input logic [cgpu_pkg::STR_W-1:0] z_out_o,
  input logic [1:0]                 phase_out_o,
  input logic [1:0]                 error_code_o
);

  // a stalled result stays put
  `CGPU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(x_out_o) && $stable(z_out_o) && $stable(phase_out_o) &&
    $stable(error_code_o))
  // an empty result stage always lets input in
  `CGPU_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)
  // only defined error codes reach the port
  `CGPU_ASSERT_NOW(a_err_legal, clk_i, rst_ni, out_valid_o, error_code_o != 2'd3)
  // a shown rejected result keeps its phase while it stays stalled
  `CGPU_ASSERT_NOW(a_err_phase, clk_i, rst_ni,
    out_valid_o && error_code_o != cgpu_pkg::ERR_OK && $past(out_valid_o) &&
    $past(!out_ready_i), $stable(phase_out_o))

endmodule

bind clifford_gate_pauli_update_core cgpu_checker u_cgpu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .x_out_o      (x_out_o),
  .z_out_o      (z_out_o),
  .phase_out_o  (phase_out_o),
  .error_code_o (error_code_o)
);

// ===== tb/clifford_gate_pauli_update_core_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// clifford_gate_pauli_update_core_test
// drives gates and loads into the pauli string core under random idling and
// back-pressure, predicts each updated string and error code in the bench and
// compares every result in order, across a series of qubit-count settings
// ---------------------------------------------------------------------------
module clifford_gate_pauli_update_core_test;

  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 150;
  localparam int MAX_Q       = int'(cgpu_pkg::MAX_QUBITS_DEF);

  typedef struct {
    logic [4:0]  op;
    logic [5:0]  qa;
    logic [5:0]  qb;
    logic [63:0] nx;
    logic [63:0] nz;
    logic [1:0]  nph;
  } gate_req_t;

  typedef struct {
    logic [63:0]    x;
    logic [63:0]    z;
    logic [1:0]     ph;
    cgpu_pkg::err_e err;
  } pauli_res_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_valid_i       = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_qubit_count_i = '0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic [4:0]  opcode_i          = '0;
  logic [5:0]  qubit_a_i         = '0;
  logic [5:0]  qubit_b_i         = '0;
  logic [63:0] new_x_bits_i      = '0;
  logic [63:0] new_z_bits_i      = '0;
  logic [1:0]  new_phase_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic [63:0] x_out_o;
  logic [63:0] z_out_o;
  logic [1:0]  phase_out_o;
  logic [1:0]  error_code_o;

  // bench copy of the string and the count register
  logic [63:0] pauli_x  = '0;
  logic [63:0] pauli_z  = '0;
  logic [1:0]  pauli_ph = '0;
  logic [6:0]  model_count = 7'd64;

  gate_req_t  gate_backlog[$];
  pauli_res_t expected_strings[$];
  gate_req_t  offered_gate;
  pauli_res_t seen_exp;

  bit src_idle_en  = 1'b0;
  bit sink_idle_en = 1'b0;
  bit hold_done    = 1'b0;
  int src_gap  = 0;
  int sink_gap = 0;
  int fail_count      = 0;
  int gates_sent      = 0;
  int strings_checked = 0;
  int range_rejects   = 0;
  int same_rejects    = 0;
  int count_writes    = 0;

  clifford_gate_pauli_update_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_qubit_count_i (cfg_qubit_count_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .qubit_a_i         (qubit_a_i),
    .qubit_b_i         (qubit_b_i),
    .new_x_bits_i      (new_x_bits_i),
    .new_z_bits_i      (new_z_bits_i),
    .new_phase_i       (new_phase_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .x_out_o           (x_out_o),
    .z_out_o           (z_out_o),
    .phase_out_o       (phase_out_o),
    .error_code_o      (error_code_o)
  );

  always #6 clk_i = ~clk_i;

  // ---- string update primitives ----
  function automatic void apply_s(int q);
    logic xa, za;
    xa = pauli_x[q];
    za = pauli_z[q];
    if (xa && za) pauli_ph = pauli_ph + 2'd2;
    pauli_z[q] = xa ^ za;
  endfunction

  function automatic void apply_h(int q);
    logic xa, za;
    xa = pauli_x[q];
    za = pauli_z[q];
    if (xa && za) pauli_ph = pauli_ph + 2'd2;
    pauli_x[q] = za;
    pauli_z[q] = xa;
  endfunction

  function automatic void apply_z(int q);
    apply_s(q);
    apply_s(q);
  endfunction

  function automatic void apply_sd(int q);
    apply_s(q);
    apply_s(q);
    apply_s(q);
  endfunction

  function automatic void apply_cx(int a, int b);
    logic xa, za, xb, zb;
    xa = pauli_x[a];
    za = pauli_z[a];
    xb = pauli_x[b];
    zb = pauli_z[b];
    // phase flips for control X with target Z, and for Y on both
    if ((xa && !za && zb && !xb) || (xa && za && xb && zb)) pauli_ph = pauli_ph + 2'd2;
    pauli_x[b] = xa ^ xb;
    pauli_z[a] = za ^ zb;
  endfunction

  function automatic void apply_cz(int a, int b);
    apply_h(b);
    apply_cx(a, b);
    apply_h(b);
  endfunction

  // updates the bench string by one gate or load and returns what the core should show
  function automatic pauli_res_t conjugate_gate(gate_req_t g);
    pauli_res_t  res;
    int          eff;
    int          qa, qb;
    logic [63:0] mask;
    eff = (int'(model_count) < MAX_Q) ? int'(model_count) : MAX_Q;
    qa  = int'(g.qa);
    qb  = int'(g.qb);
    res.err = cgpu_pkg::ERR_OK;
    if (g.op == cgpu_pkg::OP_LOAD) begin
      mask     = (eff >= 64) ? '1 : ((64'd1 << eff) - 64'd1);
      pauli_x  = g.nx & mask;
      pauli_z  = g.nz & mask;
      pauli_ph = g.nph;
    end else if (g.op <= cgpu_pkg::OP_SQRTZD) begin
      if (qa >= eff) begin
        res.err = cgpu_pkg::ERR_RANGE;
      end else begin
        case (g.op)
          cgpu_pkg::OP_H:                       apply_h(qa);
          cgpu_pkg::OP_S, cgpu_pkg::OP_SQRTZ:   apply_s(qa);
          cgpu_pkg::OP_SD, cgpu_pkg::OP_SQRTZD: apply_sd(qa);
          cgpu_pkg::OP_X: begin
            apply_h(qa); apply_z(qa); apply_h(qa);
          end
          cgpu_pkg::OP_Y: begin
            apply_h(qa); apply_z(qa); apply_h(qa); apply_z(qa);
          end
          cgpu_pkg::OP_Z:                       apply_z(qa);
          cgpu_pkg::OP_SQRTX: begin
            apply_sd(qa); apply_h(qa); apply_sd(qa);
          end
          cgpu_pkg::OP_SQRTY: begin
            apply_z(qa); apply_h(qa);
          end
          cgpu_pkg::OP_SQRTXD: begin
            apply_s(qa); apply_h(qa); apply_s(qa);
          end
          cgpu_pkg::OP_SQRTYD: begin
            apply_h(qa); apply_z(qa);
          end
          default: ;
        endcase
      end
    end else if (g.op <= cgpu_pkg::OP_SWAP) begin
      if (qa >= eff || qb >= eff) begin
        res.err = cgpu_pkg::ERR_RANGE;
      end else if (qa == qb) begin
        res.err = cgpu_pkg::ERR_SAME;
      end else begin
        case (g.op)
          cgpu_pkg::OP_CX: apply_cx(qa, qb);
          cgpu_pkg::OP_CY: begin
            apply_s(qa); apply_h(qa); apply_cz(qb, qa); apply_h(qa); apply_sd(qa);
          end
          cgpu_pkg::OP_CZ: apply_cz(qa, qb);
          default: begin
            apply_cx(qa, qb); apply_cx(qb, qa); apply_cx(qa, qb);
          end
        endcase
      end
    end
    // opcodes above swap leave the string alone
    res.x  = pauli_x;
    res.z  = pauli_z;
    res.ph = pauli_ph;
    return res;
  endfunction

  function automatic int pick_gap(bit en);
    return en ? int'($urandom_range(0, 8)) : 0;
  endfunction

  function automatic void queue_gate(logic [4:0] op, logic [5:0] qa, logic [5:0] qb,
                                     logic [63:0] nx, logic [63:0] nz, logic [1:0] nph);
    gate_req_t g;
    g.op  = op;
    g.qa  = qa;
    g.qb  = qb;
    g.nx  = nx;
    g.nz  = nz;
    g.nph = nph;
    gate_backlog.insert(gate_backlog.size(), g);
  endfunction

  // mostly legal gates on qubits in use, some loads, some rejects and unknown opcodes
  function automatic gate_req_t random_gate(int eff);
    gate_req_t g;
    int        r;
    r     = int'($urandom_range(0, 99));
    g.qa  = 6'($urandom);
    g.qb  = 6'($urandom);
    g.nx  = {$urandom, $urandom};
    g.nz  = {$urandom, $urandom};
    g.nph = 2'($urandom_range(0, 3));
    if (r < 8) begin
      g.op = cgpu_pkg::OP_LOAD;
    end else if (r < 11) begin
      g.op = 5'($urandom_range(17, 31));
    end else begin
      g.op = 5'($urandom_range(1, 16));
      if (r >= 16 && eff > 0) begin
        g.qa = 6'($urandom_range(0, eff - 1));
        g.qb = 6'($urandom_range(0, eff - 1));
        if (r >= 19 && eff > 1) begin
          while (g.qb == g.qa) g.qb = 6'($urandom_range(0, eff - 1));
        end
      end
    end
    return g;
  endfunction

  task automatic offer_next();
    offered_gate = gate_backlog.pop_front();
    in_valid_i   <= 1'b1;
    opcode_i     <= offered_gate.op;
    qubit_a_i    <= offered_gate.qa;
    qubit_b_i    <= offered_gate.qb;
    new_x_bits_i <= offered_gate.nx;
    new_z_bits_i <= offered_gate.nz;
    new_phase_i  <= offered_gate.nph;
  endtask

  // ---- input driver ----
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap = 0;
    end else if (in_valid_i && in_ready_o) begin
      expected_strings.insert(expected_strings.size(), conjugate_gate(offered_gate));
      gates_sent++;
      src_gap = pick_gap(src_idle_en);
      if (src_gap == 0 && gate_backlog.size() != 0) begin
        offer_next();
      end else begin
        in_valid_i <= 1'b0;
      end
    end else if (!in_valid_i) begin
      if (src_gap > 0) src_gap--;
      if (src_gap == 0 && gate_backlog.size() != 0) offer_next();
    end
  end

  // ---- result monitor ----
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_gap = 0;
    end else if (out_valid_o && out_ready_i) begin
      if (expected_strings.size() == 0) begin
        $error("result transfer with nothing expected: x %h z %h phase %0d error %0d",
               x_out_o, z_out_o, phase_out_o, error_code_o);
        fail_count++;
      end else begin
        seen_exp = expected_strings.pop_front();
        strings_checked++;
        if (seen_exp.err == cgpu_pkg::ERR_RANGE) range_rejects++;
        if (seen_exp.err == cgpu_pkg::ERR_SAME) same_rejects++;
        if (x_out_o !== seen_exp.x) begin
          $error("x_out: expected %h, got %h", seen_exp.x, x_out_o);
          fail_count++;
        end
        if (z_out_o !== seen_exp.z) begin
          $error("z_out: expected %h, got %h", seen_exp.z, z_out_o);
          fail_count++;
        end
        if (phase_out_o !== seen_exp.ph) begin
          $error("phase_out: expected %0d, got %0d", seen_exp.ph, phase_out_o);
          fail_count++;
        end
        if (error_code_o !== seen_exp.err) begin
          $error("error_code: expected %0d, got %0d", seen_exp.err, error_code_o);
          fail_count++;
        end
      end
      sink_gap = pick_gap(sink_idle_en);
      // one long hold so the core backs up and stalls its input
      if (!hold_done && strings_checked >= HOLD_AT) begin
        sink_gap  = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (sink_gap > 0) out_ready_i <= 1'b0;
    end else if (!out_ready_i) begin
      if (sink_gap > 0) sink_gap--;
      if (sink_gap == 0) out_ready_i <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (gate_backlog.size() != 0 || in_valid_i || expected_strings.size() != 0)
      @(negedge clk_i);
    // two-stage pipe, let it settle
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_count(logic [6:0] value);
    @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_qubit_count_i <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    model_count = value;
    count_writes++;
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_random(logic [6:0] value, bit src_en, bit sink_en);
    int eff;
    write_count(value);
    eff          = (int'(value) < MAX_Q) ? int'(value) : MAX_Q;
    src_idle_en  = src_en;
    sink_idle_en = sink_en;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      gate_backlog.insert(gate_backlog.size(), random_gate(eff));
    end
    wait_drained();
  endtask

  // ---- stimulus ----
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // every gate once at full width, extreme qubits
    write_count(7'd64);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    queue_gate(cgpu_pkg::OP_LOAD, 6'd0, 6'd0, '1, 64'd0, 2'd3);
    queue_gate(cgpu_pkg::OP_LOAD, 6'd63, 6'd63, {$urandom, $urandom}, {$urandom, $urandom},
               2'd1);
    queue_gate(cgpu_pkg::OP_H, 6'd0, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_S, 6'd63, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_SD, 6'd1, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_X, 6'd2, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_Y, 6'd3, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_Z, 6'd4, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_SQRTX, 6'd5, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_SQRTY, 6'd6, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_SQRTZ, 6'd7, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_SQRTXD, 6'd8, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_SQRTYD, 6'd9, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_SQRTZD, 6'd62, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_CX, 6'd0, 6'd63, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_CY, 6'd63, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_CZ, 6'd10, 6'd11, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_SWAP, 6'd62, 6'd1, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_LOAD, 6'd0, 6'd0, '1, '1, 2'd2);
    wait_drained();

    // lowered count: high bits stay, range and equal-qubit rejects, unknown opcodes
    write_count(7'd5);
    queue_gate(5'd17, 6'd0, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_H, 6'd5, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_CX, 6'd0, 6'd5, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_CX, 6'd7, 6'd7, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_CZ, 6'd2, 6'd2, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_S, 6'd4, 6'd0, '0, '0, 2'd0);
    queue_gate(5'd31, 6'd63, 6'd63, '1, '1, 2'd3);
    queue_gate(cgpu_pkg::OP_LOAD, 6'd63, 6'd0, '1, '1, 2'd1);
    wait_drained();

    // zero count rejects every gate and loads identity
    write_count(7'd0);
    queue_gate(cgpu_pkg::OP_H, 6'd0, 6'd0, '0, '0, 2'd0);
    queue_gate(cgpu_pkg::OP_LOAD, 6'd0, 6'd0, '1, '1, 2'd2);
    wait_drained();

    run_random(7'd1, 1'b1, 1'b1);
    run_random(7'd64, 1'b0, 1'b0);
    run_random(7'd127, 1'b1, 1'b0);
    run_random(7'd2, 1'b0, 1'b1);
    run_random(7'd65, 1'b1, 1'b1);
    run_random(7'd33, 1'b1, 1'b1);
    run_random(7'd64, 1'b1, 1'b1);
    run_random(7'd17, 1'b0, 1'b1);
    run_random(7'($urandom_range(3, 63)), 1'b1, 1'b1);

    repeat (10) @(posedge clk_i);
    $display("covered %0d transfers over %0d qubit-count settings, %0d strings checked",
             gates_sent, count_writes, strings_checked);
    $display("range rejects %0d, equal-qubit rejects %0d, one long receiver hold-off",
             range_rejects, same_rejects);
    if (fail_count == 0) begin
      $display("clifford_gate_pauli_update_core verification clean");
    end else begin
      $display("clifford_gate_pauli_update_core verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("clifford_gate_pauli_update_core verification failed");
    $finish;
  end

endmodule

// ===== clifford_gate_pauli_update_core.f =====
+incdir+src
src/cgpu_pkg.sv
src/cgpu_gate_unit.sv
src/clifford_gate_pauli_update_core.sv
src/cgpu_checker.sv
tb/clifford_gate_pauli_update_core_test.sv
